>>> hdl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int PAT_STORE = 16;   // pattern bytes held in the registers
   localparam int SUB_STORE = 32;   // replacement bytes held in the registers
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBST_WORD0    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBST_WORD1    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBST_WORD2    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBST_WORD3    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBST_LENGTH   = 3'd7;

   // per-cycle command to every cell of the window
   typedef struct packed {
      logic load;    // new byte goes in at the fill position
      logic shift;   // oldest byte leaves, all cells move one place down
   } cell_ctrl_type;

endpackage

>>> hdl/sfr_req_if.sv
`timescale 1ns / 1ps

interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> hdl/sfr_rsp_if.sv
`timescale 1ns / 1ps

interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       string_done;

   modport source (output valid, output out_byte, output byte_valid, output run_last,
                   output string_done, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                   input string_done, output ready);
endinterface

>>> hdl/stream_find_replace.sv
`timescale 1ns / 1ps

// Streaming find and replace on a byte string.
// req carries one text byte per beat, end_of_text on the final byte of a string.
// rsp carries the rewritten string: every leftmost, non-overlapping occurrence of
// the pattern is swapped for the replacement; byte_valid low marks an empty end
// beat, run_last flags the last beat caused by one request beat and string_done
// the final beat of the string.
// Registers are written through csr_* (index, 64-bit data) while the block is idle,
// which the user must keep to; the block does not enforce it. Ordinary bytes go
// through at one per cycle while rsp is ready and no run is pending; a single
// result beat shows on rsp the cycle after its request beat is taken. Longer runs
// (replacements, end-of-string window flushes) hold req off, one beat per cycle.
// The window is a row of MAX_PATTERN (up to 16) byte cells shifting towards the
// oldest end; all cells compare against the pattern in the same cycle.
// rsp is registered: a stalled receiver holds the beat and req waits with it.
// Synchronous reset clears the registers and leaves the window empty.

module stream_find_replace
   import sfr_pkg::*;
#(
   parameter int MAX_PATTERN = PAT_STORE,
   parameter int MAX_SUBST   = SUB_STORE
) (
   input  logic                  clock,
   input  logic                  reset,
   sfr_req_if.sink               req,
   sfr_rsp_if.source             rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int WIN_DEPTH = (MAX_PATTERN < PAT_STORE) ? MAX_PATTERN : PAT_STORE;
   localparam int SUB_DEPTH = (MAX_SUBST < SUB_STORE) ? MAX_SUBST : SUB_STORE;
   localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
   localparam int SCNT_W    = $clog2(SUB_DEPTH + 1);

   logic [CSR_DATA_W-1:0] pattern_low_ff, pattern_high_ff;
   logic [4:0]            pattern_length_ff;
   logic [CSR_DATA_W-1:0] subst_word0_ff, subst_word1_ff, subst_word2_ff, subst_word3_ff;
   logic [5:0]            subst_length_ff;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] emit_left_ff, emit_left_in;
   logic [SCNT_W-1:0] sub_left_ff, sub_left_in;
   logic [4:0]        sub_idx_ff, sub_idx_in;
   logic              marker_ff, marker_in;
   logic              eot_ff, eot_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_bv_ff, rsp_bv_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_done_ff, rsp_done_in;

   logic [FILL_W-1:0] plen, fill_up;
   logic [SCNT_W-1:0] slen;
   logic              busy, out_free, accept, go;
   logic              hit_all;
   logic [7:0]        oldest;
   cell_ctrl_type     cell_ctrl;
   logic [8*SUB_STORE-1:0] sub_vec;

   // job seen this cycle: freshly computed on a taken beat, else what is left over
   logic [FILL_W-1:0] job_e, new_e;
   logic [SCNT_W-1:0] job_s, new_s;
   logic [4:0]        job_sidx;
   logic              job_marker, new_marker, job_eot, new_clear;
   logic              pick_sub, pick_win, pick_mark, emit, last;

   assign plen = (pattern_length_ff > 5'(WIN_DEPTH)) ? FILL_W'(WIN_DEPTH)
                                                     : pattern_length_ff[FILL_W-1:0];
   assign slen = (subst_length_ff > 6'(SUB_DEPTH)) ? SCNT_W'(SUB_DEPTH)
                                                   : subst_length_ff[SCNT_W-1:0];
   assign sub_vec = {subst_word3_ff, subst_word2_ff, subst_word1_ff, subst_word0_ff};

   assign busy      = (emit_left_ff != '0) || (sub_left_ff != '0) || marker_ff;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = out_free && !busy;
   assign accept    = req.valid && req.ready;
   assign go        = out_free && (accept || busy);
   assign fill_up   = fill_ff + FILL_W'(1);

   always_comb begin
      new_e     = '0;
      new_s     = '0;
      new_clear = 1'b0;
      if (fill_up > plen) begin
         // pattern shorter than the window holds: drain down, no test this beat
         new_e = fill_up - plen + FILL_W'(plen != '0);
      end else if (fill_up == plen) begin
         if (hit_all) begin
            new_s     = slen;
            new_clear = 1'b1;
         end else begin
            new_e = FILL_W'(1);
         end
      end
      if (req.end_of_text && !new_clear) begin
         new_e = fill_up;
      end
      new_marker = req.end_of_text && (new_e == '0) && (new_s == '0);
   end

   always_comb begin
      if (accept) begin
         job_e      = new_e;
         job_s      = new_s;
         job_sidx   = '0;
         job_marker = new_marker;
         job_eot    = req.end_of_text;
      end else begin
         job_e      = emit_left_ff;
         job_s      = sub_left_ff;
         job_sidx   = sub_idx_ff;
         job_marker = marker_ff;
         job_eot    = eot_ff;
      end
      pick_sub  = job_s != '0;
      pick_win  = !pick_sub && (job_e != '0);
      pick_mark = !pick_sub && !pick_win && job_marker;
      emit      = go && (pick_sub || pick_win || pick_mark);

      emit_left_in = job_e - FILL_W'(pick_win);
      sub_left_in  = job_s - SCNT_W'(pick_sub);
      sub_idx_in   = job_sidx + 5'(pick_sub);
      marker_in    = job_marker && !pick_mark;
      eot_in       = job_eot;
      last         = (emit_left_in == '0) && (sub_left_in == '0) && !marker_in;

      if (accept) begin
         fill_in = (new_clear ? '0 : fill_up) - FILL_W'(pick_win);
      end else begin
         fill_in = fill_ff - FILL_W'(go && pick_win);
      end

      cell_ctrl.load  = accept;
      cell_ctrl.shift = go && pick_win;

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_bv_in    = rsp_bv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         rsp_byte_in  = pick_sub ? sub_vec[{job_sidx, 3'b000} +: 8]
                                 : (pick_win ? oldest : 8'h00);
         rsp_bv_in    = !pick_mark;
         rsp_last_in  = last;
         rsp_done_in  = last && job_eot;
      end
   end

   sfr_window #(
      .DEPTH  (WIN_DEPTH),
      .FILL_W (FILL_W)
   ) u_window (
      .clock    (clock),
      .ctrl     (cell_ctrl),
      .fill     (fill_ff),
      .plen     (plen),
      .new_byte (req.text_byte),
      .pattern  ({pattern_high_ff, pattern_low_ff}),
      .oldest   (oldest),
      .hit_all  (hit_all)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
         subst_word0_ff    <= '0;
         subst_word1_ff    <= '0;
         subst_word2_ff    <= '0;
         subst_word3_ff    <= '0;
         subst_length_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_write_data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_write_data;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_write_data[4:0];
            CSR_SUBST_WORD0:    subst_word0_ff    <= csr_write_data;
            CSR_SUBST_WORD1:    subst_word1_ff    <= csr_write_data;
            CSR_SUBST_WORD2:    subst_word2_ff    <= csr_write_data;
            CSR_SUBST_WORD3:    subst_word3_ff    <= csr_write_data;
            CSR_SUBST_LENGTH:   subst_length_ff   <= csr_write_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         emit_left_ff <= '0;
         sub_left_ff  <= '0;
         sub_idx_ff   <= '0;
         marker_ff    <= 1'b0;
         eot_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            fill_ff      <= fill_in;
            emit_left_ff <= emit_left_in;
            sub_left_ff  <= sub_left_in;
            sub_idx_ff   <= sub_idx_in;
            marker_ff    <= marker_in;
            eot_ff       <= eot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_bv_ff   <= rsp_bv_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = rsp_byte_ff;
   assign rsp.byte_valid  = rsp_bv_ff;
   assign rsp.run_last    = rsp_last_ff;
   assign rsp.string_done = rsp_done_ff;

endmodule

>>> hdl/sfr_cell.sv
`timescale 1ns / 1ps

module sfr_cell
   import sfr_pkg::*;
#(
   parameter int IDX    = 0,
   parameter int FILL_W = 5
) (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [FILL_W-1:0] fill,
   input  logic [FILL_W-1:0] plen,
   input  logic [7:0]        new_byte,
   input  logic [7:0]        next_eff,
   input  logic [7:0]        pat_byte,
   output logic [7:0]        eff,
   output logic              hit
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   // value of this place with the incoming byte already written
   assign eff = (ctrl.load && fill == FILL_W'(IDX)) ? new_byte : data_ff;

   assign data_in = ctrl.shift ? next_eff : eff;

   // places beyond the pattern always agree
   assign hit = (FILL_W'(IDX) >= plen) || (eff == pat_byte);

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

>>> hdl/sfr_window.sv
`timescale 1ns / 1ps

module sfr_window
   import sfr_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int FILL_W = 5
) (
   input  logic                   clock,
   input  cell_ctrl_type          ctrl,
   input  logic [FILL_W-1:0]      fill,
   input  logic [FILL_W-1:0]      plen,
   input  logic [7:0]             new_byte,
   input  logic [8*PAT_STORE-1:0] pattern,
   output logic [7:0]             oldest,
   output logic                   hit_all
);

   logic [7:0]       eff_chain [DEPTH+1];
   logic [DEPTH-1:0] hit_vec;

   assign eff_chain[DEPTH] = 8'h00;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      sfr_cell #(
         .IDX    (i),
         .FILL_W (FILL_W)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .fill     (fill),
         .plen     (plen),
         .new_byte (new_byte),
         .next_eff (eff_chain[i+1]),
         .pat_byte (pattern[8*i +: 8]),
         .eff      (eff_chain[i]),
         .hit      (hit_vec[i])
      );
   end

   assign oldest  = eff_chain[0];
   assign hit_all = &hit_vec;

endmodule
